[rtl/fdcw_pkg.sv]
// Shared types and constants of the double-cone weighting pipeline.
package fdcw_pkg;

  // configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 54;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ENABLE = 3'd0,
    CFG_ROW0   = 3'd1,
    CFG_ROW1   = 3'd2,
    CFG_ROW2   = 3'd3,
    CFG_SLOPE  = 3'd4,
    CFG_WIDTH0 = 3'd5
  } cfg_idx_e;

  // datapath widths
  localparam int unsigned CoefW  = 18;  // Q2.16 matrix coefficient
  localparam int unsigned IdxW   = 11;  // unwrapped signed frequency
  localparam int unsigned ProdW  = 29;  // coefficient times frequency
  localparam int unsigned PW     = 30;  // rotated component, Q.16
  localparam int unsigned AbsW   = 29;  // magnitude of a component
  localparam int unsigned SqW    = 58;  // square of a component
  localparam int unsigned SumSqW = 59;  // px^2 + py^2
  localparam int unsigned AzsW   = 46;  // |pz| * slope
  localparam int unsigned DenW   = 47;  // denominator, Q.32
  localparam int unsigned RhoW   = 30;  // transverse length, Q.16
  localparam int unsigned RemW   = 61;  // root remainder
  localparam int unsigned DivW   = 66;  // quotient remainder
  localparam int unsigned TW     = 19;  // ratio below 8.0, Q.16
  localparam int unsigned WW     = 30;  // exponent argument, Q.30
  localparam int unsigned AccW   = 31;  // series value, Q.30
  localparam int unsigned MaskW  = 17;  // mask, Q1.16

  localparam logic [AccW-1:0]  OneQ30  = 31'd1073741824;
  localparam logic [MaskW-1:0] MaskOne = 17'd65536;

  localparam int unsigned HornerSteps = 12;
  localparam int unsigned Squarings   = 5;

  // floor(2^32 / n) for n = 12 down to 1
  localparam logic [32:0] RecipTbl [HornerSteps] = '{
    33'd357913941, 33'd390451572, 33'd429496729, 33'd477218588,
    33'd536870912, 33'd613566756, 33'd715827882, 33'd858993459,
    33'd1073741824, 33'd1431655765, 33'd2147483648, 33'd4294967296
  };

  typedef struct packed {
    logic        [8:0]  col_index;
    logic        [8:0]  row_index;
    logic        [8:0]  slice_index;
    logic signed [31:0] data_real;
    logic signed [31:0] data_imag;
    logic        [31:0] ctf_weight;
    logic        [31:0] multiplicity_in;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] scaled_real;
    logic signed [31:0] scaled_imag;
    logic        [31:0] scaled_ctf;
    logic        [31:0] scaled_multiplicity;
    logic        [16:0] mask_value;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] data_real;
    logic signed [31:0] data_imag;
    logic        [31:0] ctf_weight;
    logic        [31:0] multiplicity_in;
  } data_t;

  typedef struct packed {
    logic den_zero;
    logic rho_nz;
    logic t_sat;
  } ratio_flags_t;

  typedef struct packed {
    data_t        data;
    ratio_flags_t flags;
  } carry_t;

endpackage

[rtl/fdcw_rho_ratio.sv]
// Pipelined square root of px^2+py^2 and division of rho by the cone denominator.
module fdcw_rho_ratio (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 valid_i,
  input  logic [58:0]          sumsq_i,
  input  logic [46:0]          den_i,
  input  fdcw_pkg::data_t      data_i,
  output logic                 valid_o,
  output logic [18:0]          t_o,
  output fdcw_pkg::ratio_flags_t flags_o,
  output fdcw_pkg::data_t      data_o
);

  localparam int unsigned SqSteps  = fdcw_pkg::RhoW;
  localparam int unsigned DivSteps = fdcw_pkg::TW;
  localparam int unsigned RemW     = fdcw_pkg::RemW;
  localparam int unsigned RhoW     = fdcw_pkg::RhoW;
  localparam int unsigned DenW     = fdcw_pkg::DenW;
  localparam int unsigned DivW     = fdcw_pkg::DivW;
  localparam int unsigned TW       = fdcw_pkg::TW;

  // root stages, one result bit each
  logic [SqSteps-1:0] sv_q, sv_in;
  logic [RemW-1:0]    rem_q [SqSteps], rem_in [SqSteps], rem_d [SqSteps];
  logic [RhoW-1:0]    root_q [SqSteps], root_in [SqSteps], root_d [SqSteps];
  logic [DenW-1:0]    sden_q [SqSteps], sden_in [SqSteps];
  fdcw_pkg::data_t    sdat_q [SqSteps], sdat_in [SqSteps];

  always_comb begin
    logic [RemW-1:0] cand;
    cand = '0;
    sv_in[0]   = valid_i;
    rem_in[0]  = RemW'(sumsq_i);
    root_in[0] = '0;
    sden_in[0] = den_i;
    sdat_in[0] = data_i;
    for (int k = 1; k < SqSteps; k++) begin
      sv_in[k]   = sv_q[k-1];
      rem_in[k]  = rem_q[k-1];
      root_in[k] = root_q[k-1];
      sden_in[k] = sden_q[k-1];
      sdat_in[k] = sdat_q[k-1];
    end
    for (int k = 0; k < SqSteps; k++) begin
      cand = (RemW'(root_in[k]) << (SqSteps - k)) + (RemW'(1) << (2 * (SqSteps - 1 - k)));
      if (rem_in[k] >= cand) begin
        rem_d[k]  = rem_in[k] - cand;
        root_d[k] = root_in[k] | (RhoW'(1) << (SqSteps - 1 - k));
      end else begin
        rem_d[k]  = rem_in[k];
        root_d[k] = root_in[k];
      end
    end
  end

  // quotient setup stage
  logic                   dv0_q;
  logic [DivW-1:0]        rr0_q;
  logic [DenW-1:0]        dden0_q;
  fdcw_pkg::ratio_flags_t flg0_q, flg0_d;
  fdcw_pkg::data_t        ddat0_q;
  logic [RhoW-1:0]        rho;
  logic [DenW-1:0]        rden;

  assign rho  = root_q[SqSteps-1];
  assign rden = sden_q[SqSteps-1];

  always_comb begin
    flg0_d.den_zero = (rden == '0);
    flg0_d.rho_nz   = (rho != '0);
    // t >= 8.0 exactly when rho * 2^13 >= den
    flg0_d.t_sat    = ((DivW'(rho) << 13) >= DivW'(rden));
  end

  // quotient stages, one bit each
  logic [DivSteps-1:0]    qv_q, qv_in;
  logic [DivW-1:0]        rr_q [DivSteps], rr_in [DivSteps], rr_d [DivSteps];
  logic [TW-1:0]          quo_q [DivSteps], quo_in [DivSteps], quo_d [DivSteps];
  logic [DenW-1:0]        qden_q [DivSteps], qden_in [DivSteps];
  fdcw_pkg::ratio_flags_t qflg_q [DivSteps], qflg_in [DivSteps];
  fdcw_pkg::data_t        qdat_q [DivSteps], qdat_in [DivSteps];

  always_comb begin
    logic [DivW-1:0] dsh;
    dsh = '0;
    qv_in[0]   = dv0_q;
    rr_in[0]   = rr0_q;
    quo_in[0]  = '0;
    qden_in[0] = dden0_q;
    qflg_in[0] = flg0_q;
    qdat_in[0] = ddat0_q;
    for (int k = 1; k < DivSteps; k++) begin
      qv_in[k]   = qv_q[k-1];
      rr_in[k]   = rr_q[k-1];
      quo_in[k]  = quo_q[k-1];
      qden_in[k] = qden_q[k-1];
      qflg_in[k] = qflg_q[k-1];
      qdat_in[k] = qdat_q[k-1];
    end
    for (int k = 0; k < DivSteps; k++) begin
      dsh = DivW'(qden_in[k]) << (DivSteps - 1 - k);
      if (rr_in[k] >= dsh) begin
        rr_d[k]  = rr_in[k] - dsh;
        quo_d[k] = quo_in[k] | (TW'(1) << (DivSteps - 1 - k));
      end else begin
        rr_d[k]  = rr_in[k];
        quo_d[k] = quo_in[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q  <= '0;
      dv0_q <= 1'b0;
      qv_q  <= '0;
    end else if (adv_i) begin
      sv_q  <= sv_in;
      dv0_q <= sv_q[SqSteps-1];
      qv_q  <= qv_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int k = 0; k < SqSteps; k++) begin
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
        sden_q[k] <= sden_in[k];
        sdat_q[k] <= sdat_in[k];
      end
      rr0_q   <= DivW'(rho) << 32;
      dden0_q <= rden;
      flg0_q  <= flg0_d;
      ddat0_q <= sdat_q[SqSteps-1];
      for (int k = 0; k < DivSteps; k++) begin
        rr_q[k]   <= rr_d[k];
        quo_q[k]  <= quo_d[k];
        qden_q[k] <= qden_in[k];
        qflg_q[k] <= qflg_in[k];
        qdat_q[k] <= qdat_in[k];
      end
    end
  end

  assign valid_o = qv_q[DivSteps-1];
  assign t_o     = quo_q[DivSteps-1];
  assign flags_o = qflg_q[DivSteps-1];
  assign data_o  = qdat_q[DivSteps-1];

endmodule

[rtl/fdcw_exp.sv]
// Pipelined exp(-t*t/2) by a Horner series and repeated squaring, rounded to Q1.16.
module fdcw_exp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             valid_i,
  input  logic [18:0]      t_i,
  input  fdcw_pkg::carry_t carry_i,
  output logic             valid_o,
  output logic [16:0]      e16_o,
  output fdcw_pkg::carry_t carry_o
);

  localparam int unsigned Steps = fdcw_pkg::HornerSteps;
  localparam int unsigned Sqr   = fdcw_pkg::Squarings;
  localparam int unsigned WW    = fdcw_pkg::WW;
  localparam int unsigned AccW  = fdcw_pkg::AccW;
  localparam int unsigned MaskW = fdcw_pkg::MaskW;

  // argument stage: w = t*t >> 8
  logic             wv_q;
  logic [WW-1:0]    w_q;
  fdcw_pkg::carry_t wc_q;

  // Horner step: multiply, reciprocal multiply, correct and subtract
  logic [Steps-1:0]  av_q, bv_q, cv_q, hv_in;
  logic [60:0]       a_prod_q [Steps];
  logic [WW-1:0]     a_w_q [Steps], b_w_q [Steps], c_w_q [Steps], h_w_in [Steps];
  logic [AccW-1:0]   b_x_q [Steps], b_q0_q [Steps], c_acc_q [Steps], h_acc_in [Steps];
  logic [AccW-1:0]   b_x_d [Steps], b_q0_d [Steps], c_acc_d [Steps];
  fdcw_pkg::carry_t  a_c_q [Steps], b_c_q [Steps], c_c_q [Steps], h_c_in [Steps];

  always_comb begin
    logic [AccW-1:0] ndiv;
    logic [AccW-1:0] rem;
    logic [AccW-1:0] quo;
    ndiv = '0;
    rem  = '0;
    quo  = '0;
    hv_in[0]    = wv_q;
    h_w_in[0]   = w_q;
    h_acc_in[0] = fdcw_pkg::OneQ30;
    h_c_in[0]   = wc_q;
    for (int j = 1; j < Steps; j++) begin
      hv_in[j]    = cv_q[j-1];
      h_w_in[j]   = c_w_q[j-1];
      h_acc_in[j] = c_acc_q[j-1];
      h_c_in[j]   = c_c_q[j-1];
    end
    for (int j = 0; j < Steps; j++) begin
      b_x_d[j]  = AccW'(a_prod_q[j] >> 30);
      b_q0_d[j] = AccW'((64'(b_x_d[j]) * 64'(fdcw_pkg::RecipTbl[j])) >> 32);
      ndiv = AccW'(Steps - j);
      // the reciprocal estimate is at most one low
      rem = b_x_q[j] - AccW'(b_q0_q[j] * ndiv);
      quo = (rem >= ndiv) ? b_q0_q[j] + AccW'(1) : b_q0_q[j];
      c_acc_d[j] = fdcw_pkg::OneQ30 - quo;
    end
  end

  // squaring stages
  logic [Sqr-1:0]   sv_q;
  logic [AccW-1:0]  s_acc_q [Sqr], s_acc_in [Sqr];
  fdcw_pkg::carry_t s_c_q [Sqr], s_c_in [Sqr];
  logic [Sqr-1:0]   sv_in;

  always_comb begin
    sv_in[0]    = cv_q[Steps-1];
    s_acc_in[0] = c_acc_q[Steps-1];
    s_c_in[0]   = c_c_q[Steps-1];
    for (int k = 1; k < Sqr; k++) begin
      sv_in[k]    = sv_q[k-1];
      s_acc_in[k] = s_acc_q[k-1];
      s_c_in[k]   = s_c_q[k-1];
    end
  end

  // rounding stage
  logic             ov_q;
  logic [MaskW-1:0] e_q, e_d;
  fdcw_pkg::carry_t oc_q;
  logic [17:0]      e_round;

  always_comb begin
    e_round = 18'((32'(s_acc_q[Sqr-1]) + 32'd8192) >> 14);
    e_d = (e_round > 18'(fdcw_pkg::MaskOne)) ? fdcw_pkg::MaskOne : MaskW'(e_round);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wv_q <= 1'b0;
      av_q <= '0;
      bv_q <= '0;
      cv_q <= '0;
      sv_q <= '0;
      ov_q <= 1'b0;
    end else if (adv_i) begin
      wv_q <= valid_i;
      av_q <= hv_in;
      bv_q <= av_q;
      cv_q <= bv_q;
      sv_q <= sv_in;
      ov_q <= sv_q[Sqr-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      w_q  <= WW'((38'(t_i) * 38'(t_i)) >> 8);
      wc_q <= carry_i;
      for (int j = 0; j < Steps; j++) begin
        a_prod_q[j] <= 61'(h_w_in[j]) * 61'(h_acc_in[j]);
        a_w_q[j]    <= h_w_in[j];
        a_c_q[j]    <= h_c_in[j];
        b_x_q[j]    <= b_x_d[j];
        b_q0_q[j]   <= b_q0_d[j];
        b_w_q[j]    <= a_w_q[j];
        b_c_q[j]    <= a_c_q[j];
        c_acc_q[j]  <= c_acc_d[j];
        c_w_q[j]    <= b_w_q[j];
        c_c_q[j]    <= b_c_q[j];
      end
      for (int k = 0; k < Sqr; k++) begin
        s_acc_q[k] <= AccW'((62'(s_acc_in[k]) * 62'(s_acc_in[k])) >> 30);
        s_c_q[k]   <= s_c_in[k];
      end
      e_q  <= e_d;
      oc_q <= s_c_q[Sqr-1];
    end
  end

  assign valid_o = ov_q;
  assign e16_o   = e_q;
  assign carry_o = oc_q;

endmodule

[rtl/fourier_double_cone_weight_unit.sv]
// Top level of the double-cone weighting pipeline for half-spectrum voxels.
// Throughput: one voxel per cycle while the output is not stalled; 30 root
// stages, the quotient stages and 12 three-stage Horner steps make up most of the depth.
// An output stall while the output is valid freezes the whole pipeline; input stall follows it.
// Reset clears all valid bits and loads the register reset values.
module fourier_double_cone_weight_unit #(
  parameter int unsigned MAX_BOX = 512
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  fdcw_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output fdcw_pkg::out_item_t out_item_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [53:0]         cfg_data_i
);

  localparam int unsigned CoefW  = fdcw_pkg::CoefW;
  localparam int unsigned IdxW   = fdcw_pkg::IdxW;
  localparam int unsigned ProdW  = fdcw_pkg::ProdW;
  localparam int unsigned PW     = fdcw_pkg::PW;
  localparam int unsigned AbsW   = fdcw_pkg::AbsW;
  localparam int unsigned SqW    = fdcw_pkg::SqW;
  localparam int unsigned SumSqW = fdcw_pkg::SumSqW;
  localparam int unsigned AzsW   = fdcw_pkg::AzsW;
  localparam int unsigned DenW   = fdcw_pkg::DenW;
  localparam int unsigned MaskW  = fdcw_pkg::MaskW;
  localparam int unsigned Half   = MAX_BOX / 2;

  typedef logic signed [ProdW-1:0] prod_t;

  // configuration registers
  logic        enable_q;
  logic [53:0] row_q [3];
  logic [16:0] slope_q;
  logic [15:0] width0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      row_q[0] <= 54'd65536;
      row_q[1] <= 54'd17179869184;
      row_q[2] <= 54'd4503599627370496;
      slope_q  <= 17'd5712;
      width0_q <= 16'd512;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fdcw_pkg::CFG_ENABLE: enable_q <= cfg_data_i[0];
        fdcw_pkg::CFG_ROW0:   row_q[0] <= cfg_data_i;
        fdcw_pkg::CFG_ROW1:   row_q[1] <= cfg_data_i;
        fdcw_pkg::CFG_ROW2:   row_q[2] <= cfg_data_i;
        fdcw_pkg::CFG_SLOPE:  slope_q  <= cfg_data_i[16:0];
        fdcw_pkg::CFG_WIDTH0: width0_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // hold every stage while the output waits
  logic adv;
  logic out_valid_q;
  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  // stage 1: unwrap and coefficient products
  logic signed [IdxW-1:0] fx, fy, fz;
  logic [IdxW-1:0]        ry, rz;
  prod_t                  prod_d [3][3], prod_q [3][3];
  logic                   v1_q;
  fdcw_pkg::data_t        dat_in, dat1_q;

  always_comb begin
    logic signed [CoefW-1:0] coef;
    coef = '0;
    ry = {2'b00, in_item_i.row_index};
    rz = {2'b00, in_item_i.slice_index};
    fx = $signed({2'b00, in_item_i.col_index});
    fy = (ry < IdxW'(Half)) ? $signed(ry) : $signed(ry - IdxW'(MAX_BOX));
    fz = (rz < IdxW'(Half)) ? $signed(rz) : $signed(rz - IdxW'(MAX_BOX));
    for (int r = 0; r < 3; r++) begin
      coef = $signed(row_q[r][0 +: CoefW]);
      prod_d[r][0] = prod_t'(coef) * prod_t'(fx);
      coef = $signed(row_q[r][CoefW +: CoefW]);
      prod_d[r][1] = prod_t'(coef) * prod_t'(fy);
      coef = $signed(row_q[r][2*CoefW +: CoefW]);
      prod_d[r][2] = prod_t'(coef) * prod_t'(fz);
    end
    dat_in.data_real       = in_item_i.data_real;
    dat_in.data_imag       = in_item_i.data_imag;
    dat_in.ctf_weight      = in_item_i.ctf_weight;
    dat_in.multiplicity_in = in_item_i.multiplicity_in;
  end

  // stage 2: row sums
  logic signed [PW-1:0] p_d [3], p_q [3];
  logic                 v2_q;
  fdcw_pkg::data_t      dat2_q;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      p_d[r] = PW'(prod_q[r][0]) + PW'(prod_q[r][1]) + PW'(prod_q[r][2]);
    end
  end

  // stage 3: squares and axial term
  logic [AbsW-1:0] ax, ay, az;
  logic [SqW-1:0]  sqx_q, sqy_q;
  logic [AzsW-1:0] azs_q;
  logic            v3_q;
  fdcw_pkg::data_t dat3_q;

  assign ax = AbsW'(p_q[0][PW-1] ? -p_q[0] : p_q[0]);
  assign ay = AbsW'(p_q[1][PW-1] ? -p_q[1] : p_q[1]);
  assign az = AbsW'(p_q[2][PW-1] ? -p_q[2] : p_q[2]);

  // stage 4: sum of squares and denominator
  logic [SumSqW-1:0] sumsq_q;
  logic [DenW-1:0]   den_q;
  logic              v4_q;
  fdcw_pkg::data_t   dat4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_q  <= prod_d;
      dat1_q  <= dat_in;
      p_q     <= p_d;
      dat2_q  <= dat1_q;
      sqx_q   <= SqW'(ax) * SqW'(ax);
      sqy_q   <= SqW'(ay) * SqW'(ay);
      azs_q   <= AzsW'(az) * AzsW'(slope_q);
      dat3_q  <= dat2_q;
      sumsq_q <= SumSqW'(sqx_q) + SumSqW'(sqy_q);
      den_q   <= DenW'(azs_q) + (DenW'(width0_q) << 24);
      dat4_q  <= dat3_q;
    end
  end

  // root and ratio
  logic                   rv;
  logic [18:0]            t_val;
  fdcw_pkg::ratio_flags_t rflags;
  fdcw_pkg::data_t        rdat;
  fdcw_pkg::carry_t       rcarry;

  fdcw_rho_ratio u_rho_ratio (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (v4_q),
    .sumsq_i (sumsq_q),
    .den_i   (den_q),
    .data_i  (dat4_q),
    .valid_o (rv),
    .t_o     (t_val),
    .flags_o (rflags),
    .data_o  (rdat)
  );

  assign rcarry.data  = rdat;
  assign rcarry.flags = rflags;

  // exponential
  logic             ev;
  logic [16:0]      e16;
  fdcw_pkg::carry_t ecarry;

  fdcw_exp u_exp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (rv),
    .t_i     (t_val),
    .carry_i (rcarry),
    .valid_o (ev),
    .e16_o   (e16),
    .carry_o (ecarry)
  );

  // mask select stage
  logic             vm_q;
  logic [MaskW-1:0] mask_d, mask_q;
  fdcw_pkg::data_t  datm_q;

  always_comb begin
    if (!enable_q) begin
      mask_d = fdcw_pkg::MaskOne;
    end else if (ecarry.flags.den_zero) begin
      // zero over zero gives no weight at all
      mask_d = ecarry.flags.rho_nz ? fdcw_pkg::MaskOne : '0;
    end else if (ecarry.flags.t_sat) begin
      mask_d = fdcw_pkg::MaskOne;
    end else begin
      mask_d = fdcw_pkg::MaskOne - e16;
    end
  end

  // scale stage: products
  logic                vp_q;
  logic signed [49:0]  pre_q, pim_q;
  logic        [48:0]  pctf_q, pmul_q;
  logic [MaskW-1:0]    maskp_q;

  // output stage: round to nearest with halves up, saturate
  fdcw_pkg::out_item_t out_d, out_q;

  always_comb begin
    logic signed [50:0] sr, si;
    logic        [49:0] uc, um;
    sr = 51'(pre_q) + 51'sd32768;
    si = 51'(pim_q) + 51'sd32768;
    uc = 50'(pctf_q) + 50'd32768;
    um = 50'(pmul_q) + 50'd32768;
    sr = sr >>> 16;
    si = si >>> 16;
    uc = uc >> 16;
    um = um >> 16;
    if (sr > 51'sd2147483647) begin
      out_d.scaled_real = 32'sh7FFFFFFF;
    end else if (sr < -51'sd2147483648) begin
      out_d.scaled_real = 32'sh80000000;
    end else begin
      out_d.scaled_real = 32'(sr);
    end
    if (si > 51'sd2147483647) begin
      out_d.scaled_imag = 32'sh7FFFFFFF;
    end else if (si < -51'sd2147483648) begin
      out_d.scaled_imag = 32'sh80000000;
    end else begin
      out_d.scaled_imag = 32'(si);
    end
    out_d.scaled_ctf          = (uc > 50'hFFFFFFFF) ? 32'hFFFFFFFF : 32'(uc);
    out_d.scaled_multiplicity = (um > 50'hFFFFFFFF) ? 32'hFFFFFFFF : 32'(um);
    out_d.mask_value          = maskp_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q        <= 1'b0;
      vp_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vm_q        <= ev;
      vp_q        <= vm_q;
      out_valid_q <= vp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mask_q  <= mask_d;
      datm_q  <= ecarry.data;
      pre_q   <= 50'(datm_q.data_real) * 50'($signed({1'b0, mask_q}));
      pim_q   <= 50'(datm_q.data_imag) * 50'($signed({1'b0, mask_q}));
      pctf_q  <= 49'(datm_q.ctf_weight) * 49'(mask_q);
      pmul_q  <= 49'(datm_q.multiplicity_in) * 49'(mask_q);
      maskp_q <= mask_q;
      out_q   <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // checks
  a_mask_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.mask_value <= fdcw_pkg::MaskOne))
    else $error("mask above one");

  a_zero_mask_zero_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_item_o.mask_value == '0)) |->
      (out_item_o.scaled_real == '0 && out_item_o.scaled_imag == '0 &&
       out_item_o.scaled_ctf == '0 && out_item_o.scaled_multiplicity == '0))
    else $error("nonzero result under zero mask");

  a_stall_follows_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall out of step with output");

endmodule

[tb/fourier_double_cone_weight_unit_tb.sv]
// Self-checking testbench for the double-cone weighting pipeline.
`timescale 1ns / 100ps

module fourier_double_cone_weight_unit_tb;

  localparam int unsigned BoxSize   = 512;
  localparam int unsigned Latency   = 100;
  localparam longint      CycleCap  = 400000;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  fdcw_pkg::in_item_t  in_item;
  logic                out_valid;
  logic                out_stall;
  fdcw_pkg::out_item_t out_item;
  logic                cfg_we;
  logic [2:0]          cfg_idx;
  logic [53:0]         cfg_data;

  fourier_double_cone_weight_unit #(.MAX_BOX(BoxSize)) dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_item_i(in_item),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_item_o(out_item),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  // shadow copy of the weighting registers
  logic        cone_on;
  logic [53:0] rot_row [3];
  logic [16:0] slope_shadow;
  logic [15:0] cone_sigma0;

  fdcw_pkg::in_item_t  voxel_q [$];
  fdcw_pkg::out_item_t weighted_q [$];
  int        mismatches;
  longint    cycle_cnt;
  bit        idle_enable;
  bit        hold_out;
  int        hold_out_cycles;
  int        in_gap;
  int        out_gap;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint signed coef(logic [53:0] row, int col);
    logic [17:0] c;
    c = row[18*col +: 18];
    return longint'(signed'(c));
  endfunction

  function automatic longint signed unwrap_freq(logic [8:0] v);
    if (v < BoxSize / 2) return longint'(v);
    return longint'(v) - BoxSize;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // exp(-32*w) in Q.30 by Horner series then five squarings
  function automatic logic [63:0] decay_q30(logic [63:0] w30);
    logic [63:0] acc;
    acc = 64'd1 << 30;
    for (int n = 12; n >= 1; n--)
      acc = (64'd1 << 30) - ((w30 * acc) >> 30) / n;
    for (int k = 0; k < 5; k++) acc = (acc * acc) >> 30;
    return acc;
  endfunction

  function automatic logic [16:0] mask_of(fdcw_pkg::in_item_t v);
    longint signed x, y, z, px, py, pz;
    logic [63:0] ax, ay, az, rho, den, t, e16;
    logic [127:0] num;
    x  = longint'(v.col_index);
    y  = unwrap_freq(v.row_index);
    z  = unwrap_freq(v.slice_index);
    px = coef(rot_row[0], 0) * x + coef(rot_row[0], 1) * y + coef(rot_row[0], 2) * z;
    py = coef(rot_row[1], 0) * x + coef(rot_row[1], 1) * y + coef(rot_row[1], 2) * z;
    pz = coef(rot_row[2], 0) * x + coef(rot_row[2], 1) * y + coef(rot_row[2], 2) * z;
    ax = px < 0 ? -px : px;
    ay = py < 0 ? -py : py;
    az = pz < 0 ? -pz : pz;
    rho = int_sqrt(ax * ax + ay * ay);
    den = az * 64'(slope_shadow) + (64'(cone_sigma0) << 24);
    if (den == 0) return (rho != 0) ? 17'd65536 : 17'd0;
    num = 128'(rho) << 32;
    t = 64'(num / 128'(den));
    if (t >= (64'd8 << 16)) return 17'd65536;
    e16 = (decay_q30((t * t) >> 8) + 64'd8192) >> 14;
    if (e16 > 65536) e16 = 65536;
    return 17'(65536 - e16);
  endfunction

  function automatic logic [31:0] mul_signed(logic [31:0] raw, logic [16:0] m);
    longint signed q, r;
    q = longint'(signed'(raw)) * longint'(m) + 32768;
    r = q >>> 16;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  function automatic logic [31:0] mul_unsigned(logic [31:0] raw, logic [16:0] m);
    logic [63:0] r;
    r = (64'(raw) * 64'(m) + 64'd32768) >> 16;
    if (r > 64'hFFFF_FFFF) r = 64'hFFFF_FFFF;
    return r[31:0];
  endfunction

  function automatic fdcw_pkg::out_item_t weigh_voxel(fdcw_pkg::in_item_t v);
    fdcw_pkg::out_item_t o;
    logic [16:0] m;
    m = cone_on ? mask_of(v) : fdcw_pkg::MaskOne;
    o.scaled_real         = mul_signed(v.data_real, m);
    o.scaled_imag         = mul_signed(v.data_imag, m);
    o.scaled_ctf          = mul_unsigned(v.ctf_weight, m);
    o.scaled_multiplicity = mul_unsigned(v.multiplicity_in, m);
    o.mask_value          = m;
    return o;
  endfunction

  // driver: a transfer happens when valid is high and stall low
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        weighted_q.push_back(weigh_voxel(in_item));
        void'(voxel_q.pop_front());
      end
      if (in_valid && in_stall) begin
        // hold payload
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 15) == 0) begin
        in_gap <= $urandom_range(1, 18);
        in_valid <= 1'b0;
      end else begin
        // head of voxel_q is the next item to offer
        if (voxel_q.size() > 0) begin
          in_valid <= 1'b1;
          in_item  <= voxel_q[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall control
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (weighted_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", out_item);
        end else begin
          fdcw_pkg::out_item_t e;
          e = weighted_q.pop_front();
          if (e !== out_item) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %h/%h/%h/%h/%h act %h/%h/%h/%h/%h",
                       e.scaled_real, e.scaled_imag, e.scaled_ctf,
                       e.scaled_multiplicity, e.mask_value,
                       out_item.scaled_real, out_item.scaled_imag, out_item.scaled_ctf,
                       out_item.scaled_multiplicity, out_item.mask_value);
          end
        end
      end
      if (hold_out) begin
        hold_out_cycles <= hold_out_cycles + 1;
        out_stall <= 1'b1;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else if (idle_enable && $urandom_range(0, 15) == 0) begin
        out_gap <= $urandom_range(1, 18);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_cnt > CycleCap) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(fdcw_pkg::cfg_idx_e idx, logic [53:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    case (idx)
      fdcw_pkg::CFG_ENABLE: cone_on      = val[0];
      fdcw_pkg::CFG_ROW0:   rot_row[0]   = val;
      fdcw_pkg::CFG_ROW1:   rot_row[1]   = val;
      fdcw_pkg::CFG_ROW2:   rot_row[2]   = val;
      fdcw_pkg::CFG_SLOPE:  slope_shadow = val[16:0];
      fdcw_pkg::CFG_WIDTH0: cone_sigma0  = val[15:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain;
    while (voxel_q.size() != 0 || in_valid || weighted_q.size() != 0) @(posedge clk);
    repeat (Latency + 10) @(posedge clk);
  endtask

  function automatic logic [17:0] rand_coef();
    case ($urandom_range(0, 3))
      0: return 18'h10000;
      1: return 18'h30000;
      2: return 18'($urandom_range(0, 18'h3FFFF));
      default: return 18'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
      default: return $urandom();
    endcase
  endfunction

  function automatic fdcw_pkg::in_item_t rand_voxel();
    fdcw_pkg::in_item_t v;
    // mostly low frequencies, where the mask varies, with full range mixed in
    if ($urandom_range(0, 2) == 0) begin
      v.col_index   = 9'($urandom_range(0, 256));
      v.row_index   = 9'($urandom_range(0, 511));
      v.slice_index = 9'($urandom_range(0, 511));
    end else begin
      v.col_index   = 9'($urandom_range(0, 12));
      v.row_index   = 9'($urandom_range(0, 12)) - 9'd6;
      v.slice_index = 9'($urandom_range(0, 40)) - 9'd20;
    end
    v.data_real       = rand_word();
    v.data_imag       = rand_word();
    v.ctf_weight      = rand_word();
    v.multiplicity_in = rand_word();
    return v;
  endfunction

  task automatic send_random(int n);
    repeat (n) voxel_q.push_back(rand_voxel());
  endtask

  initial begin
    fdcw_pkg::in_item_t v;
    in_valid = 1'b0; in_item = '0; out_stall = 1'b0;
    cfg_we = 1'b0; cfg_idx = fdcw_pkg::CFG_ENABLE; cfg_data = '0;
    mismatches = 0; cycle_cnt = 0; idle_enable = 1'b1;
    hold_out = 1'b0; hold_out_cycles = 0; in_gap = 0; out_gap = 0;
    cone_on = 1'b0;
    rot_row[0] = 54'd65536;
    rot_row[1] = 54'd65536 << 18;
    rot_row[2] = 54'd65536 << 36;
    slope_shadow = 17'd5712;
    cone_sigma0 = 16'd512;
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: pass-through at reset, then field extremes with the cone on
    v = '{default: '0};
    voxel_q.push_back(v);
    v = '{9'd256, 9'd511, 9'd511, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'hFFFF_FFFF,
          32'hFFFF_FFFF};
    voxel_q.push_back(v);
    drain();
    write_reg(fdcw_pkg::CFG_ENABLE, 54'd1);
    for (int i = 0; i < 9; i++) begin
      fdcw_pkg::in_item_t d;
      d = '{9'(1 << i), 9'(1 << i), 9'(1 << i), 32'sh8000_0000, 32'sh7FFF_FFFF,
            32'h8000_0000, 32'h0001_0000};
      voxel_q.push_back(d);
    end
    v = '{9'd0, 9'd0, 9'd0, 32'sd65536, -32'sd65536, 32'd65536, 32'd65536};
    voxel_q.push_back(v);  // origin: rho zero
    v = '{9'd0, 9'd0, 9'd5, 32'sd65536, -32'sd1, 32'd1, 32'd3};
    voxel_q.push_back(v);  // on the axis
    v = '{9'd200, 9'd0, 9'd0, -32'sd1, 32'sd1, 32'd1, 32'd0};
    voxel_q.push_back(v);  // far out: mask saturates at one
    drain();

    // zero denominator: both the zero and nonzero rho cases
    write_reg(fdcw_pkg::CFG_WIDTH0, 54'd0);
    write_reg(fdcw_pkg::CFG_SLOPE, 54'd0);
    v = '{9'd0, 9'd0, 9'd0, 32'sd12345, 32'sd1, 32'd7, 32'd9};
    voxel_q.push_back(v);
    v = '{9'd3, 9'd0, 9'd0, 32'sd12345, 32'sd1, 32'd7, 32'd9};
    voxel_q.push_back(v);
    drain();

    // random phases across settings, extremes included
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(fdcw_pkg::CFG_ENABLE, 54'(ph != 3));
      write_reg(fdcw_pkg::CFG_ROW0, ph == 0 ? 54'd65536 : ph == 1 ? '1 :
                {rand_coef(), rand_coef(), rand_coef()});
      write_reg(fdcw_pkg::CFG_ROW1, ph == 0 ? 54'd65536 << 18 : ph == 1 ? '0 :
                {rand_coef(), rand_coef(), rand_coef()});
      write_reg(fdcw_pkg::CFG_ROW2, ph == 0 ? 54'd65536 << 36 : ph == 1 ? '1 :
                {rand_coef(), rand_coef(), rand_coef()});
      write_reg(fdcw_pkg::CFG_SLOPE, ph == 1 ? 54'd65536 : ph == 2 ? 54'd131071 :
                ph == 4 ? 54'd0 : 54'($urandom_range(0, 65536)));
      write_reg(fdcw_pkg::CFG_WIDTH0, ph == 1 ? 54'd65535 : ph == 4 ? 54'd1 :
                54'($urandom_range(1, 2048)));
      if (ph == 5) begin
        // stall the receiver long enough to back the pipeline up
        hold_out = 1'b1;
        send_random(220);
        while (hold_out_cycles < 300) @(posedge clk);
        hold_out = 1'b0;
        send_random(20);
      end else begin
        if (ph == 7) idle_enable = 1'b0;
        send_random(220);
      end
      // full pause until every result is in
      drain();
    end

    while (weighted_q.size() != 0) @(posedge clk);
    repeat (Latency + 10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
